// ===== src/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int unsigned PageBytes = 4096;
  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned MaxPages  = 16;
  localparam int unsigned Words     = 16384;
  localparam int unsigned WordW     = $clog2(Words);
  localparam int unsigned PageWords = PageBytes / 4;
  localparam int unsigned PageShift = $clog2(PageWords);
  localparam int unsigned SizeW     = 17;
  localparam int unsigned PagesW    = 5;

  // result codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StZero   = 2'd1;
  localparam logic [1:0] StOom    = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;

  typedef logic [WordW-1:0] word_t;

  // header entry; valid marks a chunk start
  typedef struct packed {
    logic             valid;
    logic             has_prev;
    word_t            prev;
    logic [SizeW-1:0] size;
    logic             free;
  } hdr_t;

  localparam int unsigned HdrW = $bits(hdr_t);

  // memory access request from the sequencer
  typedef struct packed {
    logic  we;
    word_t waddr;
    hdr_t  wdata;
    logic  re;
    word_t raddr;
  } mem_req_t;

  // finished result
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] data;
  } res_t;

  // word of the chunk that follows a chunk at w with data size sz
  function automatic word_t next_word(word_t w, logic [SizeW-1:0] sz);
    logic [SizeW:0] span;
    span = {1'b0, sz} + (SizeW+1)'(HdrBytes);
    return w + word_t'(span >> 2);
  endfunction

endpackage
`default_nettype wire

// ===== src/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: header clearing pass, first-fit walk, split, grow and merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [15:0]       request_bytes_i,
  input  wire logic [15:0]       block_offset_i,
  output      ffha_pkg::mem_req_t mem_o,
  input  wire ffha_pkg::hdr_t    rdata_i,
  output      ffha_pkg::res_t    res_o,
  input  wire logic              res_ready_i
);
  import ffha_pkg::*;

  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SFChk   = 4'd2;
  localparam logic [3:0] SR0     = 4'd3;
  localparam logic [3:0] SR1     = 4'd4;
  localparam logic [3:0] SR2     = 4'd5;
  localparam logic [3:0] SR4     = 4'd6;
  localparam logic [3:0] SR5     = 4'd7;
  localparam logic [3:0] SR6     = 4'd8;
  localparam logic [3:0] SSpWr   = 4'd9;
  localparam logic [3:0] SAStart = 4'd10;
  localparam logic [3:0] SAChk   = 4'd11;
  localparam logic [3:0] SASplit = 4'd12;
  localparam logic [3:0] SGrow   = 4'd13;
  localparam logic [3:0] SDone   = 4'd14;

  logic [3:0]        state_q, state_d, ret_q, ret_d;
  word_t             clr_q, clr_d;
  word_t             w_q, w_d, wprev_q, wprev_d, n_q, n_d, tail_q, tail_d;
  word_t             nw_q, nw_d, oldnext_q, oldnext_d;
  word_t             sp_addr_q, sp_addr_d, sp_prev_q, sp_prev_d;
  logic [SizeW-1:0]  wsize_q, wsize_d, aligned_q, aligned_d;
  logic              whp_q, whp_d, wtail_q, wtail_d, alloc_q, alloc_d;
  logic [PagesW-1:0] pages_q, pages_d;
  logic [1:0]        status_q, status_d;
  logic [15:0]       data_q, data_d;
  logic [3:0]        rel_end;
  logic [SizeW:0]    required;
  logic [16:0]       req_ext;
  logic [15:0]       off_rel;
  word_t             base;

  assign rel_end  = alloc_q ? SAStart : SDone;
  assign required = {1'b0, aligned_q} + (SizeW+1)'(HdrBytes + 4);
  assign req_ext  = {1'b0, request_bytes_i} + 17'd3;
  assign off_rel  = block_offset_i - 16'(HdrBytes);
  assign base     = word_t'(pages_q) << PageShift;

  assign in_ready_o = (state_q == SIdle);
  assign res_o = '{valid: state_q == SDone, status: status_q, data: data_q};

  // next-state and memory access
  always_comb begin
    state_d = state_q; ret_d = ret_q; clr_d = clr_q;
    w_d = w_q; wprev_d = wprev_q; n_d = n_q; tail_d = tail_q;
    nw_d = nw_q; oldnext_d = oldnext_q; sp_addr_d = sp_addr_q;
    sp_prev_d = sp_prev_q; wsize_d = wsize_q; aligned_d = aligned_q;
    whp_d = whp_q; wtail_d = wtail_q; alloc_d = alloc_q;
    pages_d = pages_q; status_d = status_q; data_d = data_q;
    mem_o = '0;
    unique case (state_q)
      SClear: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == word_t'(Words - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          alloc_d  = !cmd_i;
          status_d = StOk;
          data_d   = '0;
          if (cmd_i) begin
            if (block_offset_i < 16'(HdrBytes) || block_offset_i[1:0] != 2'b00) begin
              status_d = StBadFree;
              state_d  = SDone;
            end else begin
              w_d         = off_rel[WordW+1:2];
              mem_o.re    = 1'b1;
              mem_o.raddr = off_rel[WordW+1:2];
              state_d     = SFChk;
            end
          end else if (request_bytes_i == '0) begin
            status_d = StZero;
            state_d  = SDone;
          end else begin
            aligned_d = {req_ext[16:2], 2'b00};
            state_d   = (pages_q == '0) ? SGrow : SAStart;
          end
        end
      end
      SFChk: begin
        if (!rdata_i.valid || rdata_i.free) begin
          status_d = StBadFree;
          state_d  = SDone;
        end else begin
          wsize_d = rdata_i.size; whp_d = rdata_i.has_prev; wprev_d = rdata_i.prev;
          state_d = SR0;
        end
      end
      // release: mark free, look at the next chunk
      SR0: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = w_q;
        mem_o.wdata = '{valid: 1'b1, has_prev: whp_q, prev: wprev_q,
                        size: wsize_q, free: 1'b1};
        if (w_q != tail_q) begin
          n_d         = next_word(w_q, wsize_q);
          mem_o.re    = 1'b1;
          mem_o.raddr = next_word(w_q, wsize_q);
          state_d     = SR1;
        end else begin
          state_d = SR4;
        end
      end
      SR1: begin
        if (rdata_i.free) begin
          wsize_d     = wsize_q + SizeW'(HdrBytes) + rdata_i.size;
          mem_o.we    = 1'b1;
          mem_o.waddr = w_q;
          mem_o.wdata = '{valid: 1'b1, has_prev: whp_q, prev: wprev_q,
                          size: wsize_q + SizeW'(HdrBytes) + rdata_i.size, free: 1'b1};
          state_d     = SR2;
        end else begin
          state_d = SR4;
        end
      end
      SR2: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = n_q;
        if (n_q == tail_q) begin
          tail_d  = w_q;
          state_d = SR4;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = next_word(w_q, wsize_q);
          sp_addr_d   = next_word(w_q, wsize_q);
          sp_prev_d   = w_q;
          ret_d       = SR4;
          state_d     = SSpWr;
        end
      end
      // merge into a free previous chunk
      SR4: begin
        if (whp_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = wprev_q;
          state_d     = SR5;
        end else begin
          state_d = rel_end;
        end
      end
      SR5: begin
        if (rdata_i.free) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wprev_q;
          mem_o.wdata = '{valid: 1'b1, has_prev: rdata_i.has_prev, prev: rdata_i.prev,
                          size: rdata_i.size + SizeW'(HdrBytes) + wsize_q, free: 1'b1};
          wtail_d = (w_q == tail_q);
          if (w_q == tail_q) tail_d = wprev_q;
          state_d = SR6;
        end else begin
          state_d = rel_end;
        end
      end
      SR6: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = w_q;
        if (wtail_q) begin
          state_d = rel_end;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = next_word(w_q, wsize_q);
          sp_addr_d   = next_word(w_q, wsize_q);
          sp_prev_d   = wprev_q;
          ret_d       = rel_end;
          state_d     = SSpWr;
        end
      end
      // back link update of a following chunk
      SSpWr: begin
        mem_o.we          = 1'b1;
        mem_o.waddr       = sp_addr_q;
        mem_o.wdata       = rdata_i;
        mem_o.wdata.has_prev = 1'b1;
        mem_o.wdata.prev  = sp_prev_q;
        state_d           = ret_q;
      end
      SAStart: begin
        w_d         = '0;
        mem_o.re    = 1'b1;
        mem_o.raddr = '0;
        state_d     = SAChk;
      end
      // first-fit walk, one header a cycle
      SAChk: begin
        wsize_d = rdata_i.size; whp_d = rdata_i.has_prev; wprev_d = rdata_i.prev;
        if (rdata_i.free && rdata_i.size == aligned_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = w_q;
          mem_o.wdata = '{valid: 1'b1, has_prev: rdata_i.has_prev, prev: rdata_i.prev,
                          size: aligned_q, free: 1'b0};
          data_d      = {w_q, 2'b00} + 16'(HdrBytes);
          state_d     = SDone;
        end else if (rdata_i.free && {1'b0, rdata_i.size} >= required) begin
          nw_d        = next_word(w_q, aligned_q);
          oldnext_d   = next_word(w_q, rdata_i.size);
          wtail_d     = (w_q == tail_q);
          mem_o.we    = 1'b1;
          mem_o.waddr = next_word(w_q, aligned_q);
          mem_o.wdata = '{valid: 1'b1, has_prev: 1'b1, prev: w_q,
                          size: rdata_i.size - aligned_q - SizeW'(HdrBytes), free: 1'b1};
          state_d     = SASplit;
        end else if (w_q == tail_q) begin
          state_d = SGrow;
        end else begin
          w_d         = next_word(w_q, rdata_i.size);
          mem_o.re    = 1'b1;
          mem_o.raddr = next_word(w_q, rdata_i.size);
        end
      end
      SASplit: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = w_q;
        mem_o.wdata = '{valid: 1'b1, has_prev: whp_q, prev: wprev_q,
                        size: aligned_q, free: 1'b0};
        data_d      = {w_q, 2'b00} + 16'(HdrBytes);
        if (wtail_q) begin
          tail_d  = nw_q;
          state_d = SDone;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = oldnext_q;
          sp_addr_d   = oldnext_q;
          sp_prev_d   = nw_q;
          ret_d       = SDone;
          state_d     = SSpWr;
        end
      end
      // append one page, then release it; report out of memory at the page limit
      SGrow: begin
        if (pages_q >= PagesW'(MaxPages)) begin
          status_d = StOom;
          data_d   = '0;
          state_d  = SDone;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = base;
          mem_o.wdata = '{valid: 1'b1, has_prev: pages_q != '0, prev: tail_q,
                          size: SizeW'(PageBytes - HdrBytes), free: 1'b0};
          w_d     = base;
          wsize_d = SizeW'(PageBytes - HdrBytes);
          whp_d   = (pages_q != '0);
          wprev_d = tail_q;
          tail_d  = base;
          pages_d = pages_q + 1'b1;
          state_d = SR0;
        end
      end
      SDone: begin
        if (res_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      tail_q  <= '0;
      pages_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tail_q  <= tail_d;
      pages_q <= pages_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; w_q <= w_d; wprev_q <= wprev_d; n_q <= n_d;
    nw_q <= nw_d; oldnext_q <= oldnext_d; sp_addr_q <= sp_addr_d;
    sp_prev_q <= sp_prev_d; wsize_q <= wsize_d; aligned_q <= aligned_d;
    whp_q <= whp_d; wtail_q <= wtail_d; alloc_q <= alloc_d;
    status_q <= status_d; data_q <= data_d;
  end

endmodule
`default_nettype wire

// ===== src/first_fit_heap_allocator_unit.sv =====
// One transaction in flight; the next is taken once the previous result
// is in the output register. The chunk walk reads one header per cycle.
// After reset a clearing pass empties the header store; no transaction
// is accepted during it.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with splitting, page growth and coalescing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // request_bytes[15:0], block_offset[31:16]
  input  wire logic        s_axis_tuser,  // cmd
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // data_offset[15:0]
  output      logic [1:0]  m_axis_tuser   // status[1:0]
);
  import ffha_pkg::*;

  mem_req_t    mem_req;
  hdr_t        rdata;
  logic [HdrW-1:0] rdata_raw;
  res_t        res;
  logic        res_ready;
  logic        ovalid_q;
  logic [1:0]  ostatus_q;
  logic [15:0] odata_q;

  assign rdata     = hdr_t'(rdata_raw);
  assign res_ready = !ovalid_q || m_axis_tready;

  ffha_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .cmd_i           (s_axis_tuser),
    .request_bytes_i (s_axis_tdata[15:0]),
    .block_offset_i  (s_axis_tdata[31:16]),
    .mem_o           (mem_req),
    .rdata_i         (rdata),
    .res_o           (res),
    .res_ready_i     (res_ready)
  );

  ffha_ram #(.Width(HdrW), .Depth(Words)) u_hdr_ram (
    .clk_i,
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_ready) begin
      ovalid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      ostatus_q <= res.status;
      odata_q   <= res.data;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostatus_q;

  // never read and write one entry in the same cycle
  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("header read and write collide");

  // no header write while waiting for a new transaction
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mem_req.we)
    else $error("header write while idle");

  // failed results carry a zero offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StOk |-> m_axis_tdata == '0)
    else $error("nonzero offset on failure");

endmodule
`default_nettype wire

// ===== tb/sv/first_fit_heap_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_tb
// Self-checking bench for the first-fit heap allocator. A behavioral model
// of the arena predicts status and offset for every request. Directed
// allocate/free cases come first, then random traffic that mixes allocations
// with frees of live chunks. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;

  localparam int unsigned WMask   = Words - 1;
  localparam int unsigned CmdAlloc = 0;
  localparam int unsigned CmdFree  = 1;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] offset;
  } alloc_res_t;

  // Arena model plus queue of outstanding predicted results
  class heap_scoreboard;
    bit              chunk_free [Words];
    bit [SizeW-1:0]  chunk_size [Words];
    bit [WordW-1:0]  chunk_prev [Words];
    bit              chunk_has_prev [Words];
    bit              chunk_start [Words];
    int unsigned     pages;
    int unsigned     tail;
    alloc_res_t      pending_q[$];
    int unsigned     errors;

    function int unsigned follow(int unsigned w);
      return (w + (HdrBytes + chunk_size[w]) / 4) & WMask;
    endfunction

    // mark free and merge with free neighbors
    function void release_chunk(int unsigned w);
      int unsigned n, p, sz;
      bit at_tail;
      chunk_free[w] = 1;
      if (w != tail) begin
        n = follow(w);
        if (chunk_free[n]) begin
          sz = chunk_size[w] + HdrBytes + chunk_size[n];
          at_tail = (n == tail);
          chunk_start[n] = 0;
          chunk_size[w] = sz;
          if (at_tail) begin
            tail = w;
          end else begin
            n = follow(w);
            chunk_has_prev[n] = 1;
            chunk_prev[n] = w;
          end
        end
      end
      if (chunk_has_prev[w]) begin
        p = chunk_prev[w];
        if (chunk_free[p]) begin
          sz = chunk_size[p] + HdrBytes + chunk_size[w];
          at_tail = (w == tail);
          n = follow(w);
          chunk_start[w] = 0;
          chunk_size[p] = sz;
          chunk_free[p] = 1;
          if (at_tail) begin
            tail = p;
          end else begin
            chunk_has_prev[n] = 1;
            chunk_prev[n] = p;
          end
        end
      end
    endfunction

    // append one page as a free chunk
    function bit add_page();
      int unsigned base;
      if (pages >= MaxPages) return 0;
      if ((pages + 1) * PageBytes > 65536) return 0;
      base = (pages * PageBytes / 4) & WMask;
      chunk_free[base] = 0;
      chunk_size[base] = PageBytes - HdrBytes;
      chunk_has_prev[base] = (pages > 0);
      chunk_prev[base] = tail;
      chunk_start[base] = 1;
      tail = base;
      pages++;
      release_chunk(base);
      return 1;
    endfunction

    function alloc_res_t first_fit(int unsigned req);
      alloc_res_t r;
      int unsigned aligned, required, w, sz, nw, old_next;
      bit found, at_tail;
      r.status = StOk;
      r.offset = 0;
      aligned = ((req + 3) / 4) * 4;
      required = aligned + HdrBytes + 4;
      found = 0;
      forever begin
        if (pages > 0) begin
          w = 0;
          for (int unsigned i = 0; i < Words; i++) begin
            sz = chunk_size[w];
            if (chunk_free[w] && sz == aligned) begin
              chunk_free[w] = 0;
              found = 1;
            end else if (chunk_free[w] && sz >= required) begin
              nw = (w + (HdrBytes + aligned) / 4) & WMask;
              at_tail = (w == tail);
              old_next = follow(w);
              chunk_free[nw] = 1;
              chunk_size[nw] = sz - aligned - HdrBytes;
              chunk_has_prev[nw] = 1;
              chunk_prev[nw] = w;
              chunk_start[nw] = 1;
              chunk_free[w] = 0;
              chunk_size[w] = aligned;
              if (at_tail) begin
                tail = nw;
              end else begin
                chunk_has_prev[old_next] = 1;
                chunk_prev[old_next] = nw;
              end
              found = 1;
            end
            if (found) begin
              r.offset = (w * 4 + HdrBytes) & 16'hFFFF;
              break;
            end
            if (w == tail) break;
            w = follow(w);
          end
        end
        if (found) break;
        if (!add_page()) begin
          r.status = StOom;
          break;
        end
      end
      return r;
    endfunction

    // accepted request: update model and queue the expected result
    function alloc_res_t note_request(bit cmd, int unsigned req, int unsigned off);
      alloc_res_t r;
      int unsigned w;
      r.status = StOk;
      r.offset = 0;
      if (cmd == CmdFree) begin
        if (off < HdrBytes || off % 4 != 0) begin
          r.status = StBadFree;
        end else begin
          w = ((off - HdrBytes) / 4) & WMask;
          if (!chunk_start[w] || chunk_free[w]) r.status = StBadFree;
          else release_chunk(w);
        end
      end else if (req == 0) begin
        r.status = StZero;
      end else begin
        r = first_fit(req);
      end
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] offset);
      alloc_res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d offset %0d", status, offset);
        return;
      end
      e = pending_q.pop_front();
      if (status !== e.status || offset !== e.offset) begin
        errors++;
        if (errors <= 10)
          $display("result differs: expected status %0d offset %0d, got status %0d offset %0d",
                   e.status, e.offset, status, offset);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;  // request_bytes[15:0], block_offset[31:16]
  logic        s_axis_tuser = 0;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;      // data_offset[15:0]
  logic [1:0]  m_axis_tuser;      // status[1:0]

  heap_scoreboard sb = new();
  int unsigned    live_q[$];
  int unsigned    last_freed;
  bit             no_gaps;
  bit             long_hold;

  first_fit_heap_allocator_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  // offer one transaction, wait for acceptance, record prediction
  task automatic send(bit cmd, int unsigned req, int unsigned off);
    int unsigned gap;
    alloc_res_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {off[15:0], req[15:0]};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    r = sb.note_request(cmd, req[15:0], off[15:0]);
    if (cmd == CmdAlloc && r.status == StOk) live_q.push_back(r.offset);
    if (cmd == CmdFree && r.status == StOk) last_freed = off[15:0];
  endtask

  task automatic free_live(int unsigned idx);
    int unsigned off;
    off = live_q[idx];
    live_q.delete(idx);
    send(CmdFree, $urandom(), off);
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (long_hold) begin
        stall = 400;
        long_hold = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // run limit
  initial begin
    #100ms;
    $display("first_fit_heap_allocator_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned r, a;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: zero request, full-arena miss, splits, exact fit, bad frees
    send(CmdAlloc, 0, 16'hFFFF);
    send(CmdAlloc, 65535, 0);
    send(CmdAlloc, 65520, 0);
    free_live(0);
    send(CmdAlloc, 8, 0);
    send(CmdAlloc, 8, 0);
    send(CmdAlloc, 1, 0);
    send(CmdAlloc, 3, 0);
    send(CmdAlloc, 5, 0);
    free_live(0);
    send(CmdAlloc, 8, 0);
    send(CmdFree, 0, 0);
    send(CmdFree, 0, 2);
    send(CmdFree, 0, 8);
    send(CmdFree, 0, 65532);
    send(CmdFree, 0, 65535);
    free_live(1);
    send(CmdFree, 16'hFFFF, last_freed);
    free_live(1);
    free_live(0);
    send(CmdAlloc, 4096, 16'hAAAA);
    send(CmdAlloc, 32768, 16'h5555);

    // random traffic
    for (int i = 0; i < 1300; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == 600) long_hold = 1;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send(CmdAlloc, 0, $urandom());
      end else if (r < 50 || (r < 88 && live_q.size() == 0)) begin
        a = $urandom_range(0, 99);
        if (a < 2) a = $urandom_range(1, 65535);
        else if (a < 12) a = $urandom_range(1, 4096);
        else a = $urandom_range(1, 128);
        send(CmdAlloc, a, $urandom());
      end else if (r < 88) begin
        free_live($urandom_range(0, live_q.size() - 1));
      end else if (r < 94) begin
        send(CmdFree, $urandom(), $urandom_range(0, 65535));
      end else begin
        send(CmdFree, $urandom(), last_freed);
      end
    end
    s_axis_tvalid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("first_fit_heap_allocator_unit: match");
    end else begin
      $display("first_fit_heap_allocator_unit: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
src/ffha_pkg.sv
src/ffha_ram.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator_unit.sv
tb/sv/first_fit_heap_allocator_unit_tb.sv
